>>> sv/mps_pkg.sv
// Shared types and codes for the multilevel process scheduler.
// Used by the controller, the datapath and the top level.
package mps_pkg;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_SETSTATE = 3'd1,
    OP_CHGQUEUE = 3'd2,
    OP_SETW     = 3'd3,
    OP_AGE      = 3'd4,
    OP_DISPATCH = 3'd5,
    OP_RSVD6    = 3'd6,
    OP_RSVD7    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NOTFOUND = 3'd1,
    STS_FULL     = 3'd2,
    STS_BADQUEUE = 3'd3,
    STS_NONE     = 3'd4
  } status_t;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_NOOP  = 2'd3;

  localparam logic [1:0] Q_UNSET = 2'd0;
  localparam logic [1:0] Q_RR    = 2'd1;
  localparam logic [1:0] Q_LCFS  = 2'd2;
  localparam logic [1:0] Q_BJF   = 2'd3;

  localparam int RANK_W = 56;
  localparam logic [31:0] MAX_AGE_RESET = 32'd8000;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_FREE,
    MODE_PID,
    MODE_RR,
    MODE_LCFS,
    MODE_BJF,
    MODE_AGE,
    MODE_WALL
  } mode_t;

  typedef struct packed {
    logic  latch;
    logic  clear;
    logic  issue;
    logic  rd;
    logic  wr;
    logic  load_out;
    mode_t mode;
  } cmd_t;

  typedef struct packed {
    logic       found;
    op_t        op;
    logic [1:0] nq;
    logic       all;
    logic       out_busy;
  } sts_t;

endpackage

>>> sv/mps_ctrl.sv
// Sequencer for the scheduler: decode, table scans, read, write, result.
// Depends on mps_pkg; drives the datapath through cmd_t.
module mps_ctrl import mps_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sts_t                             sts,
  output cmd_t                             cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] cnt
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DRAIN, S_READ, S_WRITE, S_DONE
  } state_t;

  state_t     state;
  mode_t      mode;
  logic [1:0] drain;
  logic       next_phase;

  assign next_phase = (mode == MODE_RR || mode == MODE_LCFS) && !sts.found;
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    cmd.latch    = in_valid && (state == S_IDLE);
    cmd.clear    = (state == S_DECODE) || (state == S_DRAIN && drain == 2'd3 && next_phase);
    cmd.issue    = (state == S_SCAN);
    cmd.rd       = (state == S_READ);
    cmd.wr       = (state == S_WRITE);
    cmd.load_out = (state == S_DONE) && !sts.out_busy;
    cmd.mode     = mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_NONE;
      cnt   <= '0;
      drain <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          cnt <= '0;
          case (sts.op)
            OP_CREATE: begin
              mode  <= MODE_FREE;
              state <= S_SCAN;
            end
            OP_SETSTATE: begin
              mode  <= MODE_PID;
              state <= S_SCAN;
            end
            OP_CHGQUEUE: begin
              mode  <= (sts.nq == Q_UNSET) ? MODE_NONE : MODE_PID;
              state <= (sts.nq == Q_UNSET) ? S_READ : S_SCAN;
            end
            OP_SETW: begin
              mode  <= sts.all ? MODE_WALL : MODE_PID;
              state <= S_SCAN;
            end
            OP_AGE: begin
              mode  <= MODE_AGE;
              state <= S_SCAN;
            end
            OP_DISPATCH: begin
              mode  <= MODE_RR;
              state <= S_SCAN;
            end
            default: begin
              mode  <= MODE_NONE;
              state <= S_READ;
            end
          endcase
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IW'(TABLE_ENTRIES - 1)) begin
            drain <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == 2'd3) begin
            if (next_phase) begin
              mode  <= (mode == MODE_RR) ? MODE_LCFS : MODE_BJF;
              cnt   <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ:  state <= S_WRITE;
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/mps_datapath.sv
// Task table, scan pipeline with rank multipliers, and result register.
// Depends on mps_pkg; commanded by mps_ctrl.
module mps_datapath import mps_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cmd_t                             cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] cnt,
  output sts_t                             sts,
  input  logic [135:0]                     in_data,
  input  logic                             cfg_wr_en,
  input  logic [31:0]                      cfg_wr_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [23:0]                      out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int N  = TABLE_ENTRIES;

  logic [31:0] max_age;

  op_t         op;
  logic [15:0] pid;
  logic [31:0] now;
  logic [31:0] size;
  logic [1:0]  nst;
  logic [1:0]  nq;
  logic [47:0] w;
  logic        all;

  logic [1:0]  st_arr  [N];
  logic [15:0] pid_arr [N];
  logic [1:0]  q_arr   [N];
  logic [IW-1:0] rr_last;

  logic [31:0] mem_created  [N];
  logic [31:0] mem_last_run [N];
  logic [15:0] mem_disp     [N];
  logic [31:0] mem_size     [N];
  logic [47:0] mem_weights  [N];

  logic [31:0] rd_created, rd_last_run, rd_size;
  logic [15:0] rd_disp;
  logic [47:0] rd_weights;

  logic [IW-1:0] rr_start, scan_addr, rd_addr;
  logic [IW:0]   rr_sum;

  logic          b_valid, c_valid, d_valid;
  logic [IW-1:0] b_idx, c_idx, d_idx;
  logic [1:0]    b_st, c_st, d_st, b_q, c_q, d_q;
  logic [15:0]   b_pid, c_pid, d_pid;
  logic [31:0]   c_created, d_created;
  logic [47:0]   p_a, p_s;
  logic [31:0]   p_e;
  logic [RANK_W-1:0] c_sum, c_rank, d_rank;

  logic              found;
  logic [IW-1:0]     best_idx;
  logic [RANK_W-1:0] best_val, hit_val;
  logic              hit, d_run;

  logic age_hit, wr_create, wr_setst, wr_chgq, wr_setw, wr_disp, wall;
  logic we_last, we_w;
  logic [IW-1:0] last_addr, w_addr;
  logic [47:0]   w_wdata;
  logic [15:0]   disp_wdata;
  logic [1:0]    create_q;

  status_t       res_status, res_status_next;
  logic [15:0]   res_pid, res_pid_next;
  logic [1:0]    res_q, res_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MAX_AGE_RESET;
    end else if (cfg_wr_en) begin
      max_age <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= op_t'(in_data[2:0]);
      pid  <= in_data[18:3];
      now  <= in_data[50:19];
      size <= in_data[82:51];
      nst  <= in_data[84:83];
      nq   <= in_data[86:85];
      w    <= in_data[134:87];
      all  <= in_data[135];
    end
  end

  assign rr_start  = (rr_last == IW'(N - 1)) ? '0 : rr_last + 1'b1;
  assign rr_sum    = {1'b0, rr_start} + {1'b0, cnt};

  always_comb begin
    scan_addr = cnt;
    if (cmd.mode == MODE_RR) begin
      if (rr_sum >= (IW + 1)'(N)) scan_addr = IW'(rr_sum - (IW + 1)'(N));
      else scan_addr = rr_sum[IW-1:0];
    end
  end

  assign rd_addr = cmd.rd ? best_idx : scan_addr;

  assign age_hit   = b_valid && cmd.mode == MODE_AGE && b_st == ST_RUN && b_q != Q_RR
                     && (now - rd_last_run) > max_age;
  assign wr_create = cmd.wr && op == OP_CREATE && found;
  assign wr_setst  = cmd.wr && op == OP_SETSTATE && found && nst != ST_NOOP;
  assign wr_chgq   = cmd.wr && op == OP_CHGQUEUE && nq != Q_UNSET && found;
  assign wr_setw   = cmd.wr && op == OP_SETW && !all && found;
  assign wr_disp   = cmd.wr && op == OP_DISPATCH && found;
  assign wall      = cmd.issue && cmd.mode == MODE_WALL;

  assign we_last    = age_hit || wr_create || wr_chgq || wr_disp;
  assign last_addr  = age_hit ? b_idx : best_idx;
  assign we_w       = wall || wr_create || wr_setw;
  assign w_addr     = wall ? scan_addr : best_idx;
  assign w_wdata    = wr_create ? '0 : w;
  assign disp_wdata = wr_create ? '0 : ((rd_disp == 16'hFFFF) ? rd_disp : rd_disp + 1'b1);
  assign create_q   = (pid == 16'd1) ? Q_RR : ((pid > 16'd1) ? Q_LCFS : Q_UNSET);

  always_ff @(posedge clk) begin
    rd_created <= mem_created[rd_addr];
    if (wr_create) mem_created[best_idx] <= now;
  end

  always_ff @(posedge clk) begin
    rd_last_run <= mem_last_run[rd_addr];
    if (we_last) mem_last_run[last_addr] <= now;
  end

  always_ff @(posedge clk) begin
    rd_disp <= mem_disp[rd_addr];
    if (wr_create || wr_disp) mem_disp[best_idx] <= disp_wdata;
  end

  always_ff @(posedge clk) begin
    rd_size <= mem_size[rd_addr];
    if (wr_create) mem_size[best_idx] <= size;
  end

  always_ff @(posedge clk) begin
    rd_weights <= mem_weights[rd_addr];
    if (we_w) mem_weights[w_addr] <= w_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        st_arr[i]  <= ST_FREE;
        pid_arr[i] <= '0;
        q_arr[i]   <= Q_UNSET;
      end
      rr_last <= IW'(N - 1);
    end else begin
      if (wr_create) begin
        st_arr[best_idx]  <= ST_RUN;
        pid_arr[best_idx] <= pid;
        q_arr[best_idx]   <= create_q;
      end
      if (wr_setst) begin
        st_arr[best_idx] <= nst;
        if (nst == ST_FREE) begin
          pid_arr[best_idx] <= '0;
          q_arr[best_idx]   <= Q_UNSET;
        end
      end
      if (wr_chgq) q_arr[best_idx] <= nq;
      if (age_hit) q_arr[b_idx] <= Q_RR;
      if (wr_disp && cmd.mode == MODE_RR) rr_last <= best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= cmd.issue;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  assign c_sum  = RANK_W'(p_a) + RANK_W'(p_s);
  assign c_rank = (c_sum << 3) + (c_sum << 1) + RANK_W'(p_e);

  always_ff @(posedge clk) begin
    b_idx     <= scan_addr;
    b_st      <= st_arr[scan_addr];
    b_pid     <= pid_arr[scan_addr];
    b_q       <= q_arr[scan_addr];
    c_idx     <= b_idx;
    c_st      <= b_st;
    c_pid     <= b_pid;
    c_q       <= b_q;
    c_created <= rd_created;
    p_a       <= rd_weights[15:0] * rd_created;
    p_e       <= rd_weights[31:16] * rd_disp;
    p_s       <= rd_weights[47:32] * rd_size;
    d_idx     <= c_idx;
    d_st      <= c_st;
    d_pid     <= c_pid;
    d_q       <= c_q;
    d_created <= c_created;
    d_rank    <= c_rank;
  end

  assign d_run = (d_st == ST_RUN);

  always_comb begin
    hit_val = (cmd.mode == MODE_LCFS) ? RANK_W'(d_created) : d_rank;
    case (cmd.mode)
      MODE_FREE: hit = d_st == ST_FREE && !found;
      MODE_PID:  hit = d_st != ST_FREE && d_pid == pid && !found;
      MODE_RR:   hit = d_run && d_q == Q_RR && !found;
      MODE_LCFS: hit = d_run && d_q == Q_LCFS && (!found || hit_val > best_val);
      MODE_BJF:  hit = d_run && d_q == Q_BJF && (!found || hit_val < best_val);
      default:   hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.clear) begin
      found <= 1'b0;
    end else if (d_valid && hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && hit) begin
      best_idx <= d_idx;
      best_val <= hit_val;
    end
  end

  always_comb begin
    res_status_next = STS_OK;
    res_pid_next    = '0;
    res_q_next      = Q_UNSET;
    case (op)
      OP_CREATE:   if (!found) res_status_next = STS_FULL;
      OP_SETSTATE: if (!found) res_status_next = STS_NOTFOUND;
      OP_CHGQUEUE: begin
        if (nq == Q_UNSET) res_status_next = STS_BADQUEUE;
        else if (!found) res_status_next = STS_NOTFOUND;
      end
      OP_SETW:     if (!all && !found) res_status_next = STS_NOTFOUND;
      OP_DISPATCH: begin
        if (found) begin
          res_pid_next = pid_arr[best_idx];
          res_q_next   = q_arr[best_idx];
        end else begin
          res_status_next = STS_NONE;
        end
      end
      default: res_status_next = STS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      res_status <= res_status_next;
      res_pid    <= res_pid_next;
      res_q      <= res_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= {3'b000, res_q, res_pid, res_status};
  end

  always_comb begin
    sts.found    = found;
    sts.op       = op;
    sts.nq       = nq;
    sts.all      = all;
    sts.out_busy = out_valid && !out_ready;
  end

endmodule

>>> sv/multilevel_process_scheduler.sv
// Top level of the multilevel process scheduler with aging.
// Depends on mps_pkg, mps_ctrl and mps_datapath.
//
// channel  | direction | contents
// s_axis   | in        | one operation item per handshake
// m_axis   | out       | one result item per operation
// cfg      | in        | max_age write, no read-back
//
// Each table scan issues one entry per cycle into a four-stage read, multiply,
// rank and compare pipeline. Create, set state, change queue (unless queue_sel
// is unset), set weights and age run one scan; dispatch runs up to three scans.
// Operations without a scan go from decode to read, write and result. rst is
// synchronous; the table needs no clearing pass. A stalled result holds the
// next result off until taken, though the next item may already be accepted.
module multilevel_process_scheduler import mps_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0] pid[18:3] time_req[50:19] task_size[82:51] new_state[84:83]
  // queue_sel[86:85] weight_arrival[102:87] weight_executed[118:103]
  // weight_size[134:119] all_entries[135]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0] chosen_pid[18:3] chosen_queue[20:19] zero[23:21]
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;
  logic [$clog2(TABLE_ENTRIES)-1:0] cnt;

  mps_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  mps_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cnt         (cnt),
    .sts         (sts),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule

>>> sv/mps_checker.sv
// Port-level checks for the multilevel process scheduler.
// Bound to multilevel_process_scheduler; no package needed.
module mps_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [23:0]  m_axis_tdata,
  input logic         cfg_wr_en
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in flight");

  a_pid_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[20:3] == 18'd0)
    else $error("chosen task reported with error status");

  a_cfg_quiet: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |-> s_axis_tready && !m_axis_tvalid)
    else $error("max_age written with an item in flight");

endmodule

bind multilevel_process_scheduler mps_checker u_mps_checker (.*);
